// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms on clk with arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// ----- sv/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// types, constants and helpers shared by the arp cache modules
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_PACKET = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_DROP = 2'd2;

	localparam logic [10:0] MIN_ARP_LEN = 11'd28;
	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] ip_addr;
		logic [47:0] eth_addr;
		logic [15:0] hw_type;
		logic [15:0] net_type;
		logic [15:0] opcode;
		logic [31:0] tgt_ip;
		logic [10:0] payload_len;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] mac_out;
		logic        reply_needed;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic write;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic is_lookup;
		logic scan_done;
		logic out_free;
	} sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RESP
	} state_t;

	function automatic logic pkt_ok(input req_t r);
		return (r.payload_len >= MIN_ARP_LEN) && (r.hw_type == HW_ETHERNET) &&
			(r.net_type == PROTO_IPV4);
	endfunction

endpackage

// ----- sv/arpc_ram.sv -----
// ----------------------------------------------------------------------------
// arpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/arpc_dp.sv -----
// ----------------------------------------------------------------------------
// arpc_dp
// datapath: item register, table memory, valid bits, scan compare, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpc_dp import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  req_t        in_data,
	input  logic        out_stall,
	output logic        out_valid,
	output rsp_t        out_data,
	input  cmd_t        cmd,
	output sts_t        sts
);

	req_t             item_q;
	logic [31:0]      my_ip_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [IDX_W-1:0] rd_addr_q;
	logic             issue_done_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic [47:0]      found_mac_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	rsp_t             out_q;
	logic             out_vld_q;

	entry_t           rd_entry;
	entry_t           wr_entry;
	logic [IDX_W-1:0] wr_addr;
	logic             rd_en;
	logic             match;
	logic             free_slot;
	logic             scan_done;
	rsp_t             res;

	assign rd_en     = cmd.scan && !issue_done_q;
	assign match     = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_entry.ip == item_q.ip_addr);
	assign free_slot = cmp_vld_s1 && !valid_q[cmp_idx_s1];
	assign scan_done = match || (cmp_vld_s1 && (cmp_idx_s1 == LAST_IDX));

	assign wr_entry.ip  = item_q.ip_addr;
	assign wr_entry.mac = item_q.eth_addr;

	always_comb begin
		priority if (found_q) begin
			wr_addr = found_idx_q;
		end else if (free_found_q) begin
			wr_addr = free_idx_q;
		end else begin
			wr_addr = '0;
		end
	end

	arpc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (wr_addr),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_entry)
	);

	// result of the item held in item_q
	always_comb begin
		res = '0;
		unique case (item_q.req_type)
			REQ_LOOKUP: begin
				if (found_q) begin
					res.mac_out = found_mac_q;
				end else begin
					res.status = STAT_MISS;
				end
			end
			REQ_PACKET: begin
				if (!pkt_ok(item_q)) begin
					res.status = STAT_DROP;
				end else if ((item_q.opcode == OP_REQUEST) && (item_q.tgt_ip == my_ip_q)) begin
					res.reply_needed = 1'b1;
					res.reply_mac    = item_q.eth_addr;
					res.reply_ip     = item_q.ip_addr;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q <= '0;
		end else if (cfg_wr_en) begin
			my_ip_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// scan: read issued one cycle, compared the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			rd_addr_q    <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en && !scan_done;
			if (rd_en) begin
				rd_addr_q    <= rd_addr_q + 1'b1;
				issue_done_q <= (rd_addr_q == LAST_IDX);
			end
			if (match) begin
				found_q <= 1'b1;
			end
			if (free_slot && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr_q;
		if (match) begin
			found_idx_q <= cmp_idx_s1;
			found_mac_q <= rd_entry.mac;
		end
		if (free_slot && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign sts.need_scan = (in_data.req_type == REQ_LOOKUP) ||
		(in_data.req_type == REQ_INSERT) ||
		((in_data.req_type == REQ_PACKET) && pkt_ok(in_data));
	assign sts.is_lookup = (item_q.req_type == REQ_LOOKUP);
	assign sts.scan_done = scan_done;
	assign sts.out_free  = !out_vld_q || !out_stall;

	`ASSERT_CLK(a_wr_sets_valid, cmd.write |=> valid_q[$past(wr_addr)], "written slot not valid")
	`ASSERT_CLK(a_cmp_after_scan, cmp_vld_s1 |-> $past(cmd.scan), "compare without scan read")
	`ASSERT_NEVER(a_write_in_scan, cmd.write && cmd.scan, "table write during scan")

endmodule

// ----- sv/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// controller: accepts an item, sequences scan, table write and result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpc_ctrl import arpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.need_scan ? ST_SCAN : ST_RESP;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.is_lookup ? ST_RESP : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_CLK(a_res_needs_room, cmd.res_load |-> sts.out_free, "result loaded over pending transfer")
	`ASSERT_CLK(a_write_then_resp, cmd.write |=> (state_q == ST_RESP), "write not followed by result")
	`ASSERT_CLK(a_load_leaves_idle, cmd.load |=> (state_q != ST_IDLE), "accepted item not processed")

endmodule

// ----- sv/arp_cache_and_responder_unit.sv -----
// ----------------------------------------------------------------------------
// arp_cache_and_responder_unit
// A 16-entry IPv4-to-MAC table with ARP receive handling. One item is in
// work at a time. The table memory has one read port and is scanned one
// entry per cycle with the compare in the cycle after the read; a lookup,
// an insert or an accepted packet scans the table, ending early on a hit,
// while a dropped packet or an unused request kind skips the scan. A
// finished result waits in an output register and the next item is taken
// while it waits. Valid marks are cleared by reset; my_ip may be written
// whenever the unit is idle.
// ----------------------------------------------------------------------------
module arp_cache_and_responder_unit import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data
);

	cmd_t cmd;
	sts_t sts;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
